// File: rtl/core/brf_pkg.sv
`timescale 1ns / 1ps

package brf_pkg;

  // field widths of the word on both channels
  localparam int CMD_W  = 3;
  localparam int BYTE_W = 8;

  // default ring size in slots (one slot always stays empty)
  localparam int DEPTH_DEF = 256;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 3'd0,
    CMD_EXTRACT = 3'd1,
    CMD_PEEK    = 3'd2,
    CMD_COMMIT  = 3'd3,
    CMD_REWIND  = 3'd4
  } cmd_t;

endpackage

// File: rtl/core/brf_store.sv
`timescale 1ns / 1ps

module brf_store
  import brf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [BYTE_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [BYTE_W-1:0]        rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read of the slot at the read pointer, new data forwarded on a clash
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/brf_ctrl.sv
`timescale 1ns / 1ps

module brf_ctrl
  import brf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic [CMD_W-1:0]         command,
  input  logic [BYTE_W-1:0]        data_in,
  input  logic [BYTE_W-1:0]        marker,
  input  logic [BYTE_W-1:0]        rd_data,
  output logic                     wr_en,
  output logic [$clog2(DEPTH)-1:0] wr_addr,
  output logic [BYTE_W-1:0]        wr_data,
  output logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [BYTE_W-1:0]        data_out,
  output logic                     error,
  output logic [BYTE_W-1:0]        unread_count,
  output logic [BYTE_W-1:0]        free_space,
  output logic [BYTE_W-1:0]        save_marker
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = AW + 1;
  localparam int MW = (AW > BYTE_W) ? AW : BYTE_W;

  // ring pointers and counts
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [AW-1:0] read_ptr;
  logic [AW-1:0] offset;
  logic [AW-1:0] stored;

  logic [AW-1:0] head_next;
  logic [AW-1:0] tail_next;
  logic [AW-1:0] read_ptr_next;
  logic [AW-1:0] offset_next;
  logic [AW-1:0] stored_next;

  logic full;
  logic nothing_unread;
  logic marker_ok;

  // add two indexes below depth, wrapping at depth
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign full           = (stored == AW'(DEPTH - 1));
  assign nothing_unread = (stored == offset);
  assign marker_ok      = (MW'(marker) <= MW'(stored));

  // command decode and next pointer values
  always_comb begin
    head_next     = head;
    tail_next     = tail;
    read_ptr_next = read_ptr;
    offset_next   = offset;
    stored_next   = stored;
    wr_en         = 1'b0;
    data_out      = '0;
    error         = 1'b0;
    case (command)
      CMD_PUSH: begin
        if (full) begin
          error = 1'b1;
        end else begin
          wr_en       = en;
          tail_next   = wrap_add(tail, AW'(1));
          stored_next = stored + AW'(1);
        end
      end
      CMD_EXTRACT: begin
        if (nothing_unread) begin
          error = 1'b1;
        end else begin
          data_out      = rd_data;
          offset_next   = offset + AW'(1);
          read_ptr_next = wrap_add(read_ptr, AW'(1));
        end
      end
      CMD_PEEK: begin
        if (nothing_unread) begin
          error = 1'b1;
        end else begin
          data_out = rd_data;
        end
      end
      CMD_COMMIT: begin
        head_next   = read_ptr;
        offset_next = '0;
        stored_next = stored - offset;
      end
      CMD_REWIND: begin
        if (!marker_ok) begin
          error = 1'b1;
        end else begin
          offset_next   = AW'(marker);
          read_ptr_next = wrap_add(head, AW'(marker));
        end
      end
      default: begin
      end
    endcase
    // hold everything while no word is processed
    if (!en) begin
      head_next     = head;
      tail_next     = tail;
      read_ptr_next = read_ptr;
      offset_next   = offset;
      stored_next   = stored;
    end
  end

  // pointer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      read_ptr <= '0;
      offset   <= '0;
      stored   <= '0;
    end else begin
      head     <= head_next;
      tail     <= tail_next;
      read_ptr <= read_ptr_next;
      offset   <= offset_next;
      stored   <= stored_next;
    end
  end

  // memory ports, the read side prefetches the slot at the next read pointer
  assign wr_addr = tail;
  assign wr_data = data_in;
  assign rd_addr = read_ptr_next;

  // status after this word
  assign unread_count = BYTE_W'(stored_next - offset_next);
  assign free_space   = BYTE_W'(AW'(DEPTH - 1) - stored_next);
  assign save_marker  = BYTE_W'(offset_next);

endmodule

// File: rtl/core/byte_ring_fifo_with_read_commit.sv
`timescale 1ns / 1ps

// channel  | valid     | ready     | word
// ---------+-----------+-----------+-------------------------------------------------
// input    | in_valid  | in_ready  | command, data_in, marker
// output   | out_valid | out_ready | data_out, error, unread_count, free_space,
//          |           |           | save_marker
//
// one word per cycle sustained while out_ready stays high; each word is resolved in a
// single pass between the input register and the result register, the ring read port
// prefetching the byte at the next read pointer
// a word is taken into the input register, and its result is then shown from the result register
// stalls: the result register holds while out_ready is low, the input register still
// takes one more word, then in_ready drops
// reset clears pointers, counts and both valid flags; the byte store is left as it is

module byte_ring_fifo_with_read_commit
  import brf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  command,
  input  logic [BYTE_W-1:0] data_in,
  input  logic [BYTE_W-1:0] marker,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] data_out,
  output logic              error,
  output logic [BYTE_W-1:0] unread_count,
  output logic [BYTE_W-1:0] free_space,
  output logic [BYTE_W-1:0] save_marker
);

  localparam int AW = $clog2(DEPTH);

  // input register
  logic              ivalid;
  logic [CMD_W-1:0]  icmd;
  logic [BYTE_W-1:0] idata;
  logic [BYTE_W-1:0] imarker;

  logic advance;

  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [BYTE_W-1:0] wr_data;
  logic [BYTE_W-1:0] rd_data;

  logic [BYTE_W-1:0] res_data;
  logic              res_error;
  logic [BYTE_W-1:0] res_unread;
  logic [BYTE_W-1:0] res_free;
  logic [BYTE_W-1:0] res_marker;

  assign advance  = ivalid && (!out_valid || out_ready);
  assign in_ready = !ivalid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ivalid <= 1'b0;
    end else if (in_valid && in_ready) begin
      ivalid <= 1'b1;
    end else if (advance) begin
      ivalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      icmd    <= command;
      idata   <= data_in;
      imarker <= marker;
    end
  end

  // pointer control
  brf_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .en           (advance),
    .command      (icmd),
    .data_in      (idata),
    .marker       (imarker),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_addr      (rd_addr),
    .data_out     (res_data),
    .error        (res_error),
    .unread_count (res_unread),
    .free_space   (res_free),
    .save_marker  (res_marker)
  );

  // byte ring
  brf_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_out     <= res_data;
      error        <= res_error;
      unread_count <= res_unread;
      free_space   <= res_free;
      save_marker  <= res_marker;
    end
  end

  // read offset, unread and free space always add up to the capacity
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (BYTE_W'(save_marker + unread_count + free_space) == BYTE_W'(DEPTH - 1)))
    else $error("offset, unread and free space do not add up to capacity");

  // a commit leaves the read offset at zero
  assert property (@(posedge clk) disable iff (rst)
    (advance && (icmd == CMD_COMMIT)) |=> (out_valid && (save_marker == '0)))
    else $error("commit did not clear the read offset");

  // a word moved to the result register always shows up as a valid result
  assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed word lost before the result register");

endmodule
